>>> sv/fss_pkg.sv
// Shared types, register indexes and character helpers for the fuzzy subsequence scorer.
// No dependencies; imported by the core, the result queue and the top level.
package fss_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_QUERY0 = 3'd0;
  localparam logic [2:0] REG_QUERY1 = 3'd1;
  localparam logic [2:0] REG_QUERY2 = 3'd2;
  localparam logic [2:0] REG_QUERY3 = 3'd3;
  localparam logic [2:0] REG_QLEN   = 3'd4;
  localparam logic [2:0] REG_MAXPOS = 3'd5;

  // Record kinds
  localparam logic KIND_POSITION = 1'b0;
  localparam logic KIND_FINAL    = 1'b1;

  // Score bonuses
  localparam logic signed [15:0] BONUS_START    = 16'sd12;
  localparam logic signed [15:0] BONUS_BOUNDARY = 16'sd8;
  localparam logic signed [15:0] BONUS_ADJACENT = 16'sd5;
  localparam logic signed [15:0] SCORE_MAX      = 16'sd8191;
  localparam logic signed [15:0] SCORE_MIN      = -16'sd8192;
  localparam logic [14:0]        GAP_LIMIT      = 15'd16383;

  // Result queue depth
  localparam int OUTQ_DEPTH = 4;

  // One result record
  typedef struct packed {
    logic              kind;
    logic [11:0]       pos;
    logic              matched;
    logic signed [13:0] score;
    logic              last;
  } rec_t;

  // Records produced by one item: count is 0, 1 or 2, rec0 goes first
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  // ASCII upper case to lower case, everything else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Word boundary characters: space, dash, underscore, slash, dot
  function automatic logic is_boundary(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2F) || (c == 8'h2E);
  endfunction

  // Clamp a widened score back into the 14-bit range
  function automatic logic signed [15:0] sat_score(input logic signed [15:0] s);
    logic signed [15:0] r;
    r = s;
    if (s > SCORE_MAX) begin
      r = SCORE_MAX;
    end else if (s < SCORE_MIN) begin
      r = SCORE_MIN;
    end
    return r;
  endfunction

endpackage

>>> sv/fss_core.sv
// Input register, per-candidate match state and the combinational scoring step.
// Depends on fss_pkg for record types and character helpers.
module fss_core #(
  parameter int QUERY_MAX = 32,
  parameter int CAND_MAX  = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  logic [255:0]       query_flat,
  input  logic [5:0]         query_length,
  input  logic [5:0]         max_positions,
  input  logic               room,
  output fss_pkg::push_t     push
);
  import fss_pkg::*;

  localparam int QW = $clog2(QUERY_MAX + 1);
  localparam int CW = $clog2(CAND_MAX) + 1;

  // Input register
  logic        inr_valid_r, inr_valid_nxt;
  logic [7:0]  inr_char_r;
  logic        inr_has_r;
  logic        inr_end_r;
  logic        consume;

  // Candidate state
  logic [QW-1:0]      qi_r, qi_nxt;
  logic [CW-1:0]      ci_r, ci_nxt;
  logic [CW-1:0]      last_r, last_nxt;
  logic               have_r, have_nxt;
  logic signed [13:0] score_r, score_nxt;
  logic [7:0]         prev_r, prev_nxt;
  logic [5:0]         sent_r, sent_nxt;

  // Step signals
  logic [5:0]          qlen;
  logic [5:0]          qi_ext;
  logic [5:0]          qi_nxt_ext;
  logic [7:0]          qbyte;
  logic                take_char;
  logic                hit;
  logic [CW+11:0]      ci_wide;
  logic [CW-1:0]       gap;
  logic [CW+15:0]      gap_wide;
  logic [14:0]         gap_sat;
  logic signed [15:0]  bonus;
  logic signed [15:0]  delta;
  logic signed [15:0]  s1;
  logic signed [15:0]  s2;
  logic                ok;
  rec_t                pos_rec;
  rec_t                fin_rec;
  logic                send_pos;

  assign consume   = inr_valid_r && room;
  assign in_tready = !inr_valid_r || room;

  // Effective query length and the next query byte
  assign qlen   = (query_length > 6'(QUERY_MAX)) ? 6'(QUERY_MAX) : query_length;
  assign qi_ext = 6'(qi_r);
  assign qbyte  = query_flat[{qi_ext[4:0], 3'b000} +: 8];

  assign take_char = inr_has_r && (ci_r < CW'(CAND_MAX));
  assign hit = take_char && (qi_ext < qlen) && (fold_case(inr_char_r) == fold_case(qbyte));

  // Score update: position bonus first, then the adjacency or gap term, each saturated
  assign gap      = ci_r - last_r - CW'(1);
  assign gap_wide = (CW+16)'(gap);
  assign gap_sat  = (gap_wide > (CW+16)'(GAP_LIMIT)) ? GAP_LIMIT : gap_wide[14:0];

  always_comb begin
    bonus = 16'sd0;
    if (ci_r == '0) begin
      bonus = BONUS_START;
    end else if (is_boundary(prev_r)) begin
      bonus = BONUS_BOUNDARY;
    end
    delta = 16'sd0;
    if (have_r) begin
      if (ci_r == last_r + CW'(1)) begin
        delta = BONUS_ADJACENT;
      end else begin
        delta = -$signed({1'b0, gap_sat});
      end
    end
  end

  assign s1 = sat_score(16'(score_r) + bonus);
  assign s2 = sat_score(s1 + delta);

  // Next state for an accepted item
  always_comb begin
    qi_nxt    = qi_r;
    ci_nxt    = ci_r;
    last_nxt  = last_r;
    have_nxt  = have_r;
    score_nxt = score_r;
    prev_nxt  = prev_r;
    sent_nxt  = sent_r;
    send_pos  = 1'b0;
    if (hit) begin
      qi_nxt    = qi_r + QW'(1);
      last_nxt  = ci_r;
      have_nxt  = 1'b1;
      score_nxt = s2[13:0];
      if (sent_r < max_positions) begin
        send_pos = 1'b1;
        sent_nxt = sent_r + 6'd1;
      end
    end
    if (take_char) begin
      prev_nxt = inr_char_r;
      ci_nxt   = ci_r + CW'(1);
    end
  end

  assign qi_nxt_ext = 6'(qi_nxt);
  assign ok         = qi_nxt_ext >= qlen;
  assign ci_wide    = (CW+12)'(ci_r);

  // Records for this item
  always_comb begin
    pos_rec         = '0;
    pos_rec.kind    = KIND_POSITION;
    pos_rec.pos     = ci_wide[11:0];
    fin_rec         = '0;
    fin_rec.kind    = KIND_FINAL;
    fin_rec.matched = ok;
    fin_rec.score   = ok ? score_nxt : 14'sd0;
    fin_rec.last    = 1'b1;
    push            = '0;
    if (consume) begin
      if (send_pos) begin
        push.rec0 = pos_rec;
        push.rec1 = fin_rec;
        push.count = inr_end_r ? 2'd2 : 2'd1;
      end else begin
        push.rec0 = fin_rec;
        push.rec1 = fin_rec;
        push.count = inr_end_r ? 2'd1 : 2'd0;
      end
    end
  end

  always_comb begin
    inr_valid_nxt = inr_valid_r;
    if (in_tvalid && in_tready) begin
      inr_valid_nxt = 1'b1;
    end else if (consume) begin
      inr_valid_nxt = 1'b0;
    end
  end

  // Input word register, no reset on payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      inr_char_r <= in_tdata;
      inr_has_r  <= in_tuser;
      inr_end_r  <= in_tlast;
    end
  end

  // Control and candidate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
      qi_r        <= '0;
      ci_r        <= '0;
      last_r      <= '0;
      have_r      <= 1'b0;
      score_r     <= '0;
      prev_r      <= '0;
      sent_r      <= '0;
    end else begin
      inr_valid_r <= inr_valid_nxt;
      if (consume) begin
        if (inr_end_r) begin
          qi_r    <= '0;
          ci_r    <= '0;
          last_r  <= '0;
          have_r  <= 1'b0;
          score_r <= '0;
          prev_r  <= '0;
          sent_r  <= '0;
        end else begin
          qi_r    <= qi_nxt;
          ci_r    <= ci_nxt;
          last_r  <= last_nxt;
          have_r  <= have_nxt;
          score_r <= score_nxt;
          prev_r  <= prev_nxt;
          sent_r  <= sent_nxt;
        end
      end
    end
  end

endmodule

>>> sv/fss_outq.sv
// Result queue: takes up to two records a cycle and hands them out one per word.
// Depends on fss_pkg for the record and push types.
module fss_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  fss_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output fss_pkg::rec_t  head
);
  import fss_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int NW = $clog2(OUTQ_DEPTH + 1);

  rec_t            q_r [OUTQ_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            pop;
  logic [PW-1:0]   wr_next_slot;

  // Space for a worst-case item of two records
  assign room      = cnt_r <= NW'(OUTQ_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign head      = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_next_slot = wr_r + PW'(1);

  always_comb begin
    wr_nxt  = wr_r + PW'(push.count);
    rd_nxt  = pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + NW'(push.count) - NW'(pop);
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[wr_r] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      q_r[wr_next_slot] <= push.rec1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/fuzzy_subsequence_scorer_top.sv
// Top level of the fuzzy subsequence scorer: configuration registers, core and result queue.
// Depends on fss_pkg, fss_core and fss_outq.
//
//   channel | direction | tdata / data               | side band
//   in_     | sink      | [7:0] cand_char            | tuser has_char, tlast cand_end
//   out_    | source    | [11:0] pos, [12] matched,  | tuser record kind,
//           |           | [26:13] score, [31:27] 0   | tlast final record
//   cfg_    | sink      | cfg_index, cfg_data [63:0] | always ready
//
// One candidate character per clock: each word is held in the input register,
// and the scoring step then runs combinationally from it into a four-entry result queue.
// A word that yields two records gives two output words; the input stalls only while
// the queue has fewer than two free entries. Reset clears all candidate state and
// configuration; the result queue starts empty.
module fuzzy_subsequence_scorer_top #(
  parameter int QUERY_MAX = 32,
  parameter int CAND_MAX  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] cand_char
  input  logic        in_tuser,   // [0] has_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] match_position, [12] matched, [26:13] match_score
  output logic        out_tuser,  // [0] record_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fss_pkg::*;

  logic [63:0] query_r [4];
  logic [5:0]  qlen_r;
  logic [5:0]  maxpos_r;
  logic [255:0] query_flat;
  logic        room;
  push_t       push;
  rec_t        head;

  assign cfg_ready  = 1'b1;
  assign query_flat = {query_r[3], query_r[2], query_r[1], query_r[0]};

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r[0] <= '0;
      query_r[1] <= '0;
      query_r[2] <= '0;
      query_r[3] <= '0;
      qlen_r     <= '0;
      maxpos_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        REG_QUERY0, REG_QUERY1, REG_QUERY2, REG_QUERY3: query_r[cfg_index[1:0]] <= cfg_data;
        REG_QLEN:   qlen_r   <= cfg_data[5:0];
        REG_MAXPOS: maxpos_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  fss_core #(
    .QUERY_MAX(QUERY_MAX),
    .CAND_MAX (CAND_MAX)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .query_flat   (query_flat),
    .query_length (qlen_r),
    .max_positions(maxpos_r),
    .room         (room),
    .push         (push)
  );

  fss_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .head     (head)
  );

  // Output word packing
  assign out_tdata = {5'b0, head.score, head.matched, head.pos};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> sv/fss_checker.sv
// Port-level checks for the fuzzy subsequence scorer, bound to the top level.
// Depends only on the top level's ports.
module fss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Only final records close a candidate
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == out_tlast)
    else $error("tlast does not match record kind");

  // Position records carry no verdict or score
  a_pos_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:12] == 20'd0)
    else $error("position record carries verdict bits");

  // A failed candidate scores zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && !out_tdata[12] |-> out_tdata[26:13] == 14'd0)
    else $error("failed candidate has nonzero score");

endmodule

bind fuzzy_subsequence_scorer_top fss_checker u_fss_checker (.*);
